[hdl/sqcv_pkg.sv]
// ----------------------------------------------------------------------------
// sqcv_pkg: shared types and codes of the stack/queue common-values block
// Command and status codes, sequencer states and the walk step decision.
// ----------------------------------------------------------------------------
`default_nettype none

package sqcv_pkg;

    localparam int CMD_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // a list or report emits at most this many beats
    localparam int OUT_LIMIT = 16;
    localparam int EMIT_W    = $clog2(OUT_LIMIT + 1);

    localparam logic signed [DATA_W-1:0] ALL_ONES = -32'sd1;
    localparam logic signed [DATA_W-1:0] ONE      = 32'sd1;
    localparam logic signed [DATA_W-1:0] ZERO     = 32'sd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH       = 4'd0,
        CMD_POP        = 4'd1,
        CMD_ENQUEUE    = 4'd2,
        CMD_DEQUEUE    = 4'd3,
        CMD_REPORT     = 4'd4,
        CMD_LIST_QUEUE = 4'd5,
        CMD_LIST_STACK = 4'd6,
        CMD_STACK_HAS  = 4'd7,
        CMD_QUEUE_HAS  = 4'd8
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_NONE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S_ADDR,
        ST_S_DATA,
        ST_Q_ADDR,
        ST_Q_DATA,
        ST_FLUSH
    } state_t;

    // decision taken in a data state of the walk
    typedef struct packed {
        logic                     prod;    // produce a result beat
        logic signed [DATA_W-1:0] value;
        status_t                  status;
        logic                     done;    // walk ends after this step
        logic                     s_next;  // move to the next stack entry
        logic                     q_next;  // move to the next queue entry
        logic                     q_start; // latch stack entry, scan queue
        logic                     deq;     // retire the queue head
    } step_t;

endpackage

`default_nettype wire

[hdl/sqcv_cmd_if.sv]
// ----------------------------------------------------------------------------
// sqcv_cmd_if: command channel
// Valid/ready channel carrying one command and its operand per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqcv_cmd_if;
    import sqcv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

[hdl/sqcv_res_if.sv]
// ----------------------------------------------------------------------------
// sqcv_res_if: result channel
// Valid/ready channel carrying one result value, status and last flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqcv_res_if;
    import sqcv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic [STATUS_W-1:0]      status;
    logic                     last;

    modport source (output valid, output result_value, output status, output last,
                    input ready);
    modport sink   (input valid, input result_value, input status, input last,
                    output ready);
endinterface

`default_nettype wire

[hdl/stack_queue_common_values_top.sv]
// Push, enqueue and every command answered from the counts alone (empty or
// full cases) are answered as they are accepted; unknown codes are dropped
// without a beat. Pop and dequeue go through accept, memory read, decision
// and flush. Lists, membership walks and the report visit one entry at a
// time (one read port per store). Reset (rst_n low, async) empties both stores.
// ----------------------------------------------------------------------------
// stack_queue_common_values_top: bounded stack, FIFO and intersection report
// A small sequencer walks the stack and queue memories one entry at a time
// through an equality comparator on each store's read data and produces result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_queue_common_values_top #(
    parameter int STACK_DEPTH = 16,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sqcv_cmd_if.sink    cmd,
    sqcv_res_if.source  res
);
    import sqcv_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);      // stack address
    localparam int SCW = $clog2(STACK_DEPTH + 1);  // stack count
    localparam int QAW = $clog2(QUEUE_DEPTH);      // queue address
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);  // queue count
    localparam int QSW = QCW + 1;                  // head + offset sum

    // circular slot of the queue: base + offset, folded once
    function automatic logic [QAW-1:0] qslot(input logic [QAW-1:0] base,
                                             input logic [QCW-1:0] off);
        logic [QSW-1:0] sum;
        sum = QSW'(base) + QSW'(off);
        if (sum >= QSW'(QUEUE_DEPTH)) sum = sum - QSW'(QUEUE_DEPTH);
        return sum[QAW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                   state_reg, state_next;
    logic [SCW-1:0]           stack_count_reg, stack_count_next;
    logic [QAW-1:0]           queue_head_reg, queue_head_next;
    logic [QCW-1:0]           queue_count_reg, queue_count_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [EMIT_W-1:0]        emit_cnt_reg, emit_cnt_next;
    cmd_t                     mode_reg, mode_next;

    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [SCW-1:0]           sidx_reg, sidx_next;
    logic [QCW-1:0]           qidx_reg, qidx_next;
    logic signed [DATA_W-1:0] pend_value_reg, pend_value_next;
    status_t                  pend_status_reg, pend_status_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    status_t                  out_status_reg, out_status_next;
    logic                     out_last_reg, out_last_next;

    // memories and their registered read data
    logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] queue_mem [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] stack_q_reg;
    logic signed [DATA_W-1:0] queue_q_reg;
    logic                     stack_we, queue_we;
    logic [SAW-1:0]           stack_raddr, stack_waddr;
    logic [QAW-1:0]           queue_raddr, queue_waddr;

    // ------------------------------------------------------------------
    // Handshake and shared decode
    // ------------------------------------------------------------------
    logic  out_free, accept, stall;
    logic  stack_empty, stack_full, queue_empty, queue_full;
    logic  s_end, q_end, s_match, q_match, limit_hit;
    cmd_t  cmd_code;
    step_t step;

    // the output register frees when its beat is taken this cycle
    assign out_free  = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;
    assign cmd_code  = cmd_t'(cmd.command);

    // a new beat cannot enter while the pending one has nowhere to go
    assign stall = pend_valid_reg && !out_free;

    assign stack_empty = (stack_count_reg == '0);
    assign stack_full  = (stack_count_reg == SCW'(STACK_DEPTH));
    assign queue_empty = (queue_count_reg == '0);
    assign queue_full  = (queue_count_reg == QCW'(QUEUE_DEPTH));

    // walk positions: sidx counts down from the top, qidx up from the head
    assign s_end = (sidx_reg == SCW'(1));
    assign q_end = (QCW'(qidx_reg + QCW'(1)) == queue_count_reg);

    // the comparators against the key
    assign s_match = (stack_q_reg == key_reg);
    assign q_match = (queue_q_reg == key_reg);

    assign stack_raddr = SAW'(sidx_reg - SCW'(1));
    assign stack_waddr = stack_count_reg[SAW-1:0];
    assign queue_raddr = qslot(queue_head_reg, qidx_reg);
    assign queue_waddr = qslot(queue_head_reg, queue_count_reg);

    assign limit_hit = step.prod && (emit_cnt_reg == EMIT_W'(OUT_LIMIT - 1));

    // ------------------------------------------------------------------
    // Walk step decision
    // ------------------------------------------------------------------
    always_comb
    begin
        step        = '0;
        step.status = STAT_OK;
        unique case (state_reg)
            ST_S_DATA:
            begin
                unique case (mode_reg)
                    CMD_POP:
                    begin
                        step.prod  = 1'b1;
                        step.value = stack_q_reg;
                        step.done  = 1'b1;
                    end
                    CMD_LIST_STACK:
                    begin
                        step.prod   = 1'b1;
                        step.value  = stack_q_reg;
                        step.done   = s_end;
                        step.s_next = !s_end;
                    end
                    CMD_STACK_HAS:
                    begin
                        if (s_match || s_end)
                        begin
                            step.prod  = 1'b1;
                            step.value = s_match ? ONE : ZERO;
                            step.done  = 1'b1;
                        end
                        else
                        begin
                            step.s_next = 1'b1;
                        end
                    end
                    CMD_REPORT:
                    begin
                        step.q_start = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_Q_DATA:
            begin
                unique case (mode_reg)
                    CMD_DEQUEUE:
                    begin
                        step.prod  = 1'b1;
                        step.value = queue_q_reg;
                        step.done  = 1'b1;
                        step.deq   = 1'b1;
                    end
                    CMD_LIST_QUEUE:
                    begin
                        step.prod   = 1'b1;
                        step.value  = queue_q_reg;
                        step.done   = q_end;
                        step.q_next = !q_end;
                    end
                    CMD_QUEUE_HAS:
                    begin
                        if (q_match || q_end)
                        begin
                            step.prod  = 1'b1;
                            step.value = q_match ? ONE : ZERO;
                            step.done  = 1'b1;
                        end
                        else
                        begin
                            step.q_next = 1'b1;
                        end
                    end
                    CMD_REPORT:
                    begin
                        // a match or the queue tail closes this stack entry
                        if (q_match)
                        begin
                            step.prod  = 1'b1;
                            step.value = key_reg;
                        end
                        if (!(q_match || q_end))
                        begin
                            step.q_next = 1'b1;
                        end
                        else if (s_end)
                        begin
                            step.done = 1'b1;
                            if (!q_match && emit_cnt_reg == '0)
                            begin
                                step.prod   = 1'b1;
                                step.value  = ZERO;
                                step.status = STAT_NONE;
                            end
                        end
                        else
                        begin
                            step.s_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_code)
                        CMD_POP, CMD_LIST_STACK, CMD_STACK_HAS:
                            if (!stack_empty) state_next = ST_S_ADDR;
                        CMD_DEQUEUE, CMD_LIST_QUEUE, CMD_QUEUE_HAS:
                            if (!queue_empty) state_next = ST_Q_ADDR;
                        CMD_REPORT:
                            if (!stack_empty && !queue_empty) state_next = ST_S_ADDR;
                        default: ;
                    endcase
                end
            end
            ST_S_ADDR: state_next = ST_S_DATA;
            ST_Q_ADDR: state_next = ST_Q_DATA;
            ST_S_DATA, ST_Q_DATA:
            begin
                if (!stall)
                begin
                    priority if (step.done || limit_hit)     state_next = ST_FLUSH;
                    else if (step.s_next)                    state_next = ST_S_ADDR;
                    else if (step.q_next || step.q_start)    state_next = ST_Q_ADDR;
                end
            end
            ST_FLUSH:
            begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and store updates
    // ------------------------------------------------------------------
    always_comb
    begin
        stack_count_next = stack_count_reg;
        queue_head_next  = queue_head_reg;
        queue_count_next = queue_count_reg;
        out_valid_next   = out_valid_reg;
        pend_valid_next  = pend_valid_reg;
        emit_cnt_next    = emit_cnt_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        sidx_next        = sidx_reg;
        qidx_next        = qidx_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        stack_we         = 1'b0;
        queue_we         = 1'b0;

        // drop the output beat once taken; loads below override
        if (res.ready) out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next       = cmd_code;
                    key_next        = cmd.value;
                    sidx_next       = stack_count_reg;
                    qidx_next       = '0;
                    emit_cnt_next   = '0;
                    pend_valid_next = 1'b0;
                    out_last_next   = 1'b1;
                    unique case (cmd_code)
                        CMD_PUSH:
                        begin
                            out_valid_next  = 1'b1;
                            out_value_next  = cmd.value;
                            out_status_next = stack_full ? STAT_FULL : STAT_OK;
                            if (!stack_full)
                            begin
                                stack_we         = 1'b1;
                                stack_count_next = stack_count_reg + SCW'(1);
                            end
                        end
                        CMD_ENQUEUE:
                        begin
                            out_valid_next  = 1'b1;
                            out_value_next  = cmd.value;
                            out_status_next = queue_full ? STAT_FULL : STAT_OK;
                            if (!queue_full)
                            begin
                                queue_we         = 1'b1;
                                queue_count_next = queue_count_reg + QCW'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (stack_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = ALL_ONES;
                                out_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                stack_count_next = stack_count_reg - SCW'(1);
                            end
                        end
                        CMD_LIST_STACK:
                        begin
                            if (stack_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = ALL_ONES;
                                out_status_next = STAT_EMPTY;
                            end
                        end
                        CMD_DEQUEUE, CMD_LIST_QUEUE:
                        begin
                            if (queue_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = ALL_ONES;
                                out_status_next = STAT_EMPTY;
                            end
                        end
                        CMD_REPORT:
                        begin
                            if (stack_empty || queue_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = ALL_ONES;
                                out_status_next = STAT_EMPTY;
                            end
                        end
                        CMD_STACK_HAS:
                        begin
                            if (stack_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = ZERO;
                                out_status_next = STAT_OK;
                            end
                        end
                        CMD_QUEUE_HAS:
                        begin
                            if (queue_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = ZERO;
                                out_status_next = STAT_OK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_S_DATA, ST_Q_DATA:
            begin
                if (!stall)
                begin
                    if (step.prod)
                    begin
                        // advance the previous beat now that another follows
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_value_next  = pend_value_reg;
                            out_status_next = pend_status_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_value_next  = step.value;
                        pend_status_next = step.status;
                        emit_cnt_next    = emit_cnt_reg + EMIT_W'(1);
                    end
                    if (step.s_next) sidx_next = sidx_reg - SCW'(1);
                    if (step.q_next) qidx_next = qidx_reg + QCW'(1);
                    if (step.q_start)
                    begin
                        key_next  = stack_q_reg;
                        qidx_next = '0;
                    end
                    if (step.deq)
                    begin
                        queue_head_next  = qslot(queue_head_reg, QCW'(1));
                        queue_count_next = queue_count_reg - QCW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = pend_value_reg;
                    out_status_next = pend_status_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            stack_count_reg <= '0;
            queue_head_reg  <= '0;
            queue_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            emit_cnt_reg    <= '0;
            mode_reg        <= CMD_PUSH;
        end
        else
        begin
            state_reg       <= state_next;
            stack_count_reg <= stack_count_next;
            queue_head_reg  <= queue_head_next;
            queue_count_reg <= queue_count_next;
            out_valid_reg   <= out_valid_next;
            pend_valid_reg  <= pend_valid_next;
            emit_cnt_reg    <= emit_cnt_next;
            mode_reg        <= mode_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        sidx_reg        <= sidx_next;
        qidx_reg        <= qidx_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Stores: one write and one registered read port each
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (stack_we) stack_mem[stack_waddr] <= cmd.value;
        stack_q_reg <= stack_mem[stack_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we) queue_mem[queue_waddr] <= cmd.value;
        queue_q_reg <= queue_mem[queue_raddr];
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign res.valid        = out_valid_reg;
    assign res.result_value = out_value_reg;
    assign res.status       = out_status_reg;
    assign res.last         = out_last_reg;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the stack/queue common-values block
// Feeds push, pop, enqueue, dequeue, membership, list and report commands,
// first a directed opening and then episodes of random content. A built-in
// predictor of both stores works out the result beats of every accepted
// command, and the monitor compares every result beat against them in order.
// Both channels idle at random; the receiver also holds off for long
// stretches so that the block backs up onto its command input.
// ----------------------------------------------------------------------------

module testbench;
    import sqcv_pkg::*;

    // sizes of the block under test
    localparam int STACK_SLOTS = 16;
    localparam int QUEUE_SLOTS = 16;

    // command codes the block does not know; it drops them without a beat
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

    localparam int RANDOM_ITEMS  = 200;
    localparam int HOLD_FIRST    = 60;   // result beats before the first long hold-off
    localparam int HOLD_SPACING  = 400;  // result beats between later hold-offs
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 600;  // longer than a full report walk
    localparam int TIMEOUT_NS    = 5_000_000;

    // small set of operands so that searches and reports find matches
    localparam logic signed [DATA_W-1:0] OPERAND_POOL [8] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff,
        32'sh80000000, 32'sd7, 32'sd42, -32'sd100
    };

    typedef struct {
        logic [CMD_W-1:0]         code;
        logic signed [DATA_W-1:0] operand;
        int                       idle;   // cycles to stay idle after this beat
        bit                       drain;  // wait until every result is in first
    } command_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        status_t                  status;
        logic                     last;
    } result_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // local copies of the driven channel signals, known from time zero
    logic                     drv_valid   = 1'b0;
    logic [CMD_W-1:0]         drv_command = '0;
    logic signed [DATA_W-1:0] drv_value   = '0;
    logic                     drv_ready   = 1'b0;

    sqcv_cmd_if cmd_ch ();
    sqcv_res_if res_ch ();

    assign cmd_ch.valid   = drv_valid;
    assign cmd_ch.command = drv_command;
    assign cmd_ch.value   = drv_value;
    assign res_ch.ready   = drv_ready;

    stack_queue_common_values_top #(
        .STACK_DEPTH(STACK_SLOTS),
        .QUEUE_DEPTH(QUEUE_SLOTS)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch.sink),
        .res  (res_ch.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hold reset low at start, release away from the rising edge
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predicted contents of both stores
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] stack_mem [STACK_SLOTS];
    logic signed [DATA_W-1:0] queue_mem [QUEUE_SLOTS];
    int stack_fill = 0;
    int queue_head = 0;
    int queue_fill = 0;

    result_beat_t  owed_results [$];   // beats still to arrive, oldest first
    command_item_t pending_items [$];  // commands not yet offered

    // beats_predicted is written by the driver only, beats_checked by the
    // monitor only (nonblocking), so either side reads a settled count
    int beats_predicted = 0;
    int beats_checked   = 0;
    int fault_count     = 0;
    int stimulus_count  = 0;
    int sender_calm     = 0;

    function automatic result_beat_t make_beat(input logic signed [DATA_W-1:0] v,
                                               input status_t s);
        result_beat_t b;
        b.value  = v;
        b.status = s;
        b.last   = 1'b0;
        return b;
    endfunction

    function automatic bit stack_contains(input logic signed [DATA_W-1:0] v);
        for (int i = 0; i < stack_fill; i++)
            if (stack_mem[i] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit queue_contains(input logic signed [DATA_W-1:0] v);
        for (int i = 0; i < queue_fill; i++)
            if (queue_mem[(queue_head + i) % QUEUE_SLOTS] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    // Advance the predicted stores by one accepted command and queue up the
    // result beats it owes.
    task automatic apply_command(input logic [CMD_W-1:0] code,
                                 input logic signed [DATA_W-1:0] operand);
        result_beat_t outs [$];
        logic signed [DATA_W-1:0] entry;
        case (code)
            CMD_PUSH:
                if (stack_fill >= STACK_SLOTS)
                    outs.push_back(make_beat(operand, STAT_FULL));
                else
                begin
                    stack_mem[stack_fill] = operand;
                    stack_fill++;
                    outs.push_back(make_beat(operand, STAT_OK));
                end
            CMD_POP:
                if (stack_fill == 0)
                    outs.push_back(make_beat(ALL_ONES, STAT_EMPTY));
                else
                begin
                    stack_fill--;
                    outs.push_back(make_beat(stack_mem[stack_fill], STAT_OK));
                end
            CMD_ENQUEUE:
                if (queue_fill >= QUEUE_SLOTS)
                    outs.push_back(make_beat(operand, STAT_FULL));
                else
                begin
                    queue_mem[(queue_head + queue_fill) % QUEUE_SLOTS] = operand;
                    queue_fill++;
                    outs.push_back(make_beat(operand, STAT_OK));
                end
            CMD_DEQUEUE:
                if (queue_fill == 0)
                    outs.push_back(make_beat(ALL_ONES, STAT_EMPTY));
                else
                begin
                    outs.push_back(make_beat(queue_mem[queue_head], STAT_OK));
                    queue_head = (queue_head + 1) % QUEUE_SLOTS;
                    queue_fill--;
                end
            CMD_REPORT:
                if (stack_fill == 0 || queue_fill == 0)
                    outs.push_back(make_beat(ALL_ONES, STAT_EMPTY));
                else
                begin
                    // walk the stack top down, keep duplicates
                    for (int i = stack_fill - 1; i >= 0; i--)
                    begin
                        entry = stack_mem[i];
                        if (queue_contains(entry))
                            outs.push_back(make_beat(entry, STAT_OK));
                    end
                    if (outs.size() == 0)
                        outs.push_back(make_beat(ZERO, STAT_NONE));
                end
            CMD_LIST_QUEUE:
                if (queue_fill == 0)
                    outs.push_back(make_beat(ALL_ONES, STAT_EMPTY));
                else
                    for (int i = 0; i < queue_fill; i++)
                        outs.push_back(make_beat(queue_mem[(queue_head + i) % QUEUE_SLOTS],
                                                 STAT_OK));
            CMD_LIST_STACK:
                if (stack_fill == 0)
                    outs.push_back(make_beat(ALL_ONES, STAT_EMPTY));
                else
                    for (int i = stack_fill - 1; i >= 0; i--)
                        outs.push_back(make_beat(stack_mem[i], STAT_OK));
            CMD_STACK_HAS:
                outs.push_back(make_beat(stack_contains(operand) ? ONE : ZERO, STAT_OK));
            CMD_QUEUE_HAS:
                outs.push_back(make_beat(queue_contains(operand) ? ONE : ZERO, STAT_OK));
            default:
                ;
        endcase
        // a list or report is cut at the beat limit
        while (outs.size() > OUT_LIMIT)
            void'(outs.pop_back());
        if (outs.size() > 0)
            outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i])
            owed_results.push_back(outs[i]);
        beats_predicted += outs.size();
    endtask

    // ------------------------------------------------------------------
    // Idle lengths and operands
    // ------------------------------------------------------------------
    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 93)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_operand();
        if ($urandom_range(0, 99) < 60)
            return OPERAND_POOL[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    task automatic add_item(input logic [CMD_W-1:0] code,
                            input logic signed [DATA_W-1:0] operand,
                            input bit drain);
        command_item_t it;
        it.code    = code;
        it.operand = operand;
        it.drain   = drain;
        // calm stretches give back-to-back beats with no idling at all
        if (sender_calm > 0)
        begin
            sender_calm--;
            it.idle = 0;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            sender_calm = $urandom_range(20, 50);
            it.idle = 0;
        end
        else if ($urandom_range(0, 99) < 55)
            it.idle = 0;
        else
            it.idle = idle_len();
        if (code <= CMD_QUEUE_HAS)
            stimulus_count++;
        pending_items.push_back(it);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued commands, record each accepted beat
    // ------------------------------------------------------------------
    int            gap_left = 0;
    command_item_t offered;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid   <= 1'b0;
            drv_command <= '0;
            drv_value   <= '0;
            gap_left    <= 0;
        end
        else
        begin
            if (drv_valid && cmd_ch.ready)
                apply_command(drv_command, drv_value);
            // the slot is free once the current beat is taken or none is up
            if (!drv_valid || cmd_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    drv_valid <= 1'b0;
                end
                else if (pending_items.size() > 0 &&
                         (!pending_items[0].drain || beats_predicted == beats_checked))
                begin
                    offered     = pending_items.pop_front();
                    drv_valid   <= 1'b1;
                    drv_command <= offered.code;
                    drv_value   <= offered.operand;
                    gap_left    <= offered.idle;
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random, check every result beat in order
    // ------------------------------------------------------------------
    int           stall_left = 0;
    int           rx_calm    = 0;
    int           hold_mark  = HOLD_FIRST;
    result_beat_t head_result;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_ready     <= 1'b0;
            stall_left    <= 0;
            rx_calm       <= 0;
            hold_mark     <= HOLD_FIRST;
            beats_checked <= 0;
        end
        else
        begin
            if (res_ch.valid && drv_ready)
            begin
                beats_checked <= beats_checked + 1;
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing owed, value %0d status %0d last %0b",
                             $time, res_ch.result_value, res_ch.status, res_ch.last);
                    fault_count++;
                end
                else
                begin
                    head_result = owed_results.pop_front();
                    if (res_ch.result_value !== head_result.value)
                    begin
                        $display("%0t: result_value expected %0d, got %0d",
                                 $time, head_result.value, res_ch.result_value);
                        fault_count++;
                    end
                    if (res_ch.status !== head_result.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, head_result.status, res_ch.status);
                        fault_count++;
                    end
                    if (res_ch.last !== head_result.last)
                    begin
                        $display("%0t: last expected %0b, got %0b",
                                 $time, head_result.last, res_ch.last);
                        fault_count++;
                    end
                end
            end

            // hold off for a long stretch now and then, so the block backs
            // up and stalls its command input while the driver keeps offering
            if (beats_checked >= hold_mark)
            begin
                hold_mark  <= hold_mark + HOLD_SPACING;
                stall_left <= HOLD_CYCLES;
                drv_ready  <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                drv_ready  <= 1'b0;
            end
            else
            begin
                drv_ready <= 1'b1;
                if (rx_calm > 0)
                    rx_calm <= rx_calm - 1;
                else if ($urandom_range(0, 99) < 3)
                    rx_calm <= $urandom_range(40, 120);
                else if ($urandom_range(0, 99) < 30)
                    stall_left <= idle_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    int episode;
    int pick;
    int count;
    bit drain;

    initial
    begin
        // directed opening: every command on empty stores, the extremes of
        // the operand, unknown codes, a report with no match and one with
        // duplicate matches
        add_item(CMD_POP,        32'sd0,        1'b0);
        add_item(CMD_DEQUEUE,    32'sd0,        1'b0);
        add_item(CMD_LIST_STACK, 32'sd0,        1'b0);
        add_item(CMD_LIST_QUEUE, 32'sd0,        1'b0);
        add_item(CMD_REPORT,     32'sd0,        1'b0);
        add_item(CMD_STACK_HAS,  32'sd0,        1'b0);
        add_item(CMD_QUEUE_HAS,  32'sd0,        1'b0);
        add_item(CMD_UNUSED_LO,  32'sd5,        1'b0);
        add_item(CMD_UNUSED_HI,  -32'sd1,       1'b0);
        add_item(CMD_PUSH,       32'sh7fffffff, 1'b0);
        add_item(CMD_PUSH,       32'sh80000000, 1'b0);
        add_item(CMD_PUSH,       32'sh7fffffff, 1'b0);
        add_item(CMD_ENQUEUE,    32'sh12345678, 1'b0);
        add_item(CMD_REPORT,     32'sd0,        1'b0);
        add_item(CMD_ENQUEUE,    32'sh7fffffff, 1'b0);
        add_item(CMD_REPORT,     32'sd0,        1'b0);
        add_item(CMD_STACK_HAS,  32'sh80000000, 1'b0);
        add_item(CMD_QUEUE_HAS,  32'sh7fffffff, 1'b0);
        add_item(CMD_LIST_STACK, 32'sd0,        1'b0);
        add_item(CMD_LIST_QUEUE, 32'sd0,        1'b0);
        add_item(CMD_POP,        32'sd0,        1'b0);
        add_item(CMD_DEQUEUE,    32'sd0,        1'b0);
        add_item(CMD_PUSH,       -32'sd1,       1'b0);
        add_item(CMD_ENQUEUE,    32'sd0,        1'b0);
        add_item(CMD_REPORT,     32'sd0,        1'b0);

        // random episodes; open with a stack fill and a queue fill so that
        // both full cases and a full-size report come early
        stimulus_count = 0;
        episode = 0;
        while (stimulus_count < RANDOM_ITEMS)
        begin
            pick  = (episode == 0) ? 0 : (episode == 1) ? 20 : $urandom_range(0, 99);
            drain = (episode == 0) || ($urandom_range(0, 9) == 0);
            if (pick < 30)
            begin
                // fill past the top to hit the full case
                count = $urandom_range(17, 20);
                for (int j = 0; j < count; j++)
                    add_item(pick < 15 ? CMD_PUSH : CMD_ENQUEUE, pick_operand(),
                             drain && j == 0);
            end
            else if (pick < 50)
            begin
                // drain, sometimes past empty
                count = $urandom_range(3, 19);
                for (int j = 0; j < count; j++)
                    add_item(pick < 40 ? CMD_POP : CMD_DEQUEUE, 32'(pick_operand()),
                             drain && j == 0);
            end
            else if (pick < 70)
            begin
                // searches, lists and reports over whatever is stored
                count = $urandom_range(3, 6);
                for (int j = 0; j < count; j++)
                    add_item(CMD_W'($urandom_range(CMD_REPORT, CMD_QUEUE_HAS)),
                             pick_operand(), drain && j == 0);
            end
            else
            begin
                // mixed commands with a sprinkle of unknown codes
                count = $urandom_range(5, 12);
                for (int j = 0; j < count; j++)
                    if ($urandom_range(0, 19) == 0)
                        add_item(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                                 $urandom(), drain && j == 0);
                    else
                        add_item(CMD_W'($urandom_range(CMD_PUSH, CMD_QUEUE_HAS)),
                                 pick_operand(), drain && j == 0);
            end
            episode++;
        end

        // wait for every command to go out, then for every owed beat
        @(posedge rst_n);
        while (pending_items.size() > 0 || drv_valid)
            @(posedge clk);
        while (beats_predicted != beats_checked)
            @(posedge clk);
        // let any stray beat show up before judging
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
